// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file of the record deque.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define RDQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define RDQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/rdq_pkg.sv -----
// Shared constants, codes, types and ring helpers of the record deque.
package rdq_pkg;

    localparam int DEPTH     = 64;
    localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W     = 7;
    localparam int NAME_HI_W = 64;
    localparam int NAME_LO_W = 8;
    localparam int PHONE_W   = 32;
    localparam int REC_W     = NAME_HI_W + NAME_LO_W + PHONE_W;
    localparam int CMD_W     = 3;
    localparam int STATUS_W  = 2;

    localparam int NAME_LO_LSB = NAME_HI_W;
    localparam int PHONE_LSB   = NAME_HI_W + NAME_LO_W;
    localparam int CNT_LSB     = REC_W;

    localparam int S_TDATA_W = ((REC_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((REC_W + CNT_W + 7) / 8) * 8;
    localparam int S_PAD_W   = S_TDATA_W - REC_W;
    localparam int M_PAD_W   = M_TDATA_W - REC_W - CNT_W;

    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_LIST       = 3'd4;

    localparam logic [STATUS_W-1:0] STAT_POPPED = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_LISTED = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY  = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_FULL   = 2'd3;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [REC_W-1:0]  t_rec;

    typedef enum logic {
        ST_IDLE,
        ST_BUSY
    } t_state;

    function automatic t_addr ring_next(input t_addr i);
        ring_next = (i == t_addr'(DEPTH - 1)) ? '0 : i + t_addr'(1);
    endfunction

    function automatic t_addr ring_prev(input t_addr i);
        ring_prev = (i == '0) ? t_addr'(DEPTH - 1) : i - t_addr'(1);
    endfunction

endpackage

// ----- rtl/rdq_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
module rdq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/record_deque.sv -----
// Top level of the record deque: ring-store double-ended queue of name/phone records.
// Records sit in one RAM of DEPTH entries. A push writes the RAM and gives no
// beat unless the store is full. A pop reads the registered RAM read port and
// gives one beat. A list of N records makes one RAM read per record after the
// accepting cycle and gives N beats with tlast on the back record. Empty and
// full statuses give one beat with no RAM read. A command is taken
// once the previous one has finished and the output register is free or being
// emptied; a stalled output holds the list walk in place. Every beat carries the
// entry count after the operation.
module record_deque (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // name_first_eight[63:0], name_ninth_char[71:64], phone[103:72]
    input  logic [rdq_pkg::S_TDATA_W-1:0]  i_s_tdata,
    // command[2:0]
    input  logic [rdq_pkg::CMD_W-1:0]      i_s_tuser,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // out_name_first_eight[63:0], out_name_ninth_char[71:64], out_phone[103:72],
    // entry_count[110:104], zero pad [111]
    output logic [rdq_pkg::M_TDATA_W-1:0]  o_m_tdata,
    // status[1:0]
    output logic [rdq_pkg::STATUS_W-1:0]   o_m_tuser,
    // last_of_run
    output logic                           o_m_tlast
);

    rdq_pkg::t_state r_state, n_state;
    rdq_pkg::t_addr  r_head, n_head;
    rdq_pkg::t_addr  r_tail, n_tail;
    rdq_pkg::t_cnt   r_count, n_count;
    rdq_pkg::t_cnt   r_left, n_left;
    rdq_pkg::t_addr  r_ptr, n_ptr;
    logic            r_pend, n_pend;
    logic            r_pend_last, n_pend_last;
    logic [rdq_pkg::STATUS_W-1:0] r_pend_status, n_pend_status;

    logic                         r_out_valid;
    logic [rdq_pkg::STATUS_W-1:0] r_out_status;
    rdq_pkg::t_rec                r_out_rec;
    rdq_pkg::t_cnt                r_out_count;
    logic                         r_out_last;

    logic                         out_free;
    logic                         s_acc;
    logic                         is_full;
    logic                         is_empty;
    logic                         move;
    logic                         issue;
    logic                         ld;
    logic                         ld_from_ram;
    logic                         ld_last;
    logic [rdq_pkg::STATUS_W-1:0] ld_status;
    logic                         ram_we;
    rdq_pkg::t_addr               ram_waddr;
    logic                         ram_re;
    rdq_pkg::t_addr               ram_raddr;
    rdq_pkg::t_rec                ram_rdata;

    assign out_free = !r_out_valid || i_m_tready;
    assign s_acc    = i_s_tvalid && out_free;
    assign is_full  = (r_count == rdq_pkg::CNT_W'(rdq_pkg::DEPTH));
    assign is_empty = (r_count == '0);

    rdq_ram #(
        .WIDTH (rdq_pkg::REC_W),
        .DEPTH (rdq_pkg::DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_s_tdata[rdq_pkg::REC_W-1:0]),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= rdq_pkg::ST_IDLE;
            r_head        <= '0;
            r_tail        <= '0;
            r_count       <= '0;
            r_left        <= '0;
            r_ptr         <= '0;
            r_pend        <= 1'b0;
            r_pend_last   <= 1'b0;
            r_pend_status <= rdq_pkg::STAT_POPPED;
        end else begin
            r_state       <= n_state;
            r_head        <= n_head;
            r_tail        <= n_tail;
            r_count       <= n_count;
            r_left        <= n_left;
            r_ptr         <= n_ptr;
            r_pend        <= n_pend;
            r_pend_last   <= n_pend_last;
            r_pend_status <= n_pend_status;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_head        = r_head;
        n_tail        = r_tail;
        n_count       = r_count;
        n_left        = r_left;
        n_ptr         = r_ptr;
        n_pend        = r_pend;
        n_pend_last   = r_pend_last;
        n_pend_status = r_pend_status;
        o_s_tready    = 1'b0;
        move          = 1'b0;
        issue         = 1'b0;
        ld            = 1'b0;
        ld_from_ram   = 1'b0;
        ld_last       = 1'b1;
        ld_status     = rdq_pkg::STAT_POPPED;
        ram_we        = 1'b0;
        ram_waddr     = r_tail;
        ram_re        = 1'b0;
        ram_raddr     = r_ptr;
        unique case (r_state)
            rdq_pkg::ST_IDLE: begin
                o_s_tready = out_free;
                if (s_acc) begin
                    unique case (i_s_tuser) inside
                        rdq_pkg::CMD_PUSH_FRONT, rdq_pkg::CMD_PUSH_BACK: begin
                            if (is_full) begin
                                ld        = 1'b1;
                                ld_status = rdq_pkg::STAT_FULL;
                            end else begin
                                ram_we  = 1'b1;
                                n_count = r_count + rdq_pkg::CNT_W'(1);
                                if (i_s_tuser == rdq_pkg::CMD_PUSH_FRONT) begin
                                    ram_waddr = rdq_pkg::ring_prev(r_head);
                                    n_head    = rdq_pkg::ring_prev(r_head);
                                end else begin
                                    ram_waddr = r_tail;
                                    n_tail    = rdq_pkg::ring_next(r_tail);
                                end
                            end
                        end
                        rdq_pkg::CMD_POP_FRONT, rdq_pkg::CMD_POP_BACK: begin
                            if (is_empty) begin
                                ld        = 1'b1;
                                ld_status = rdq_pkg::STAT_EMPTY;
                            end else begin
                                ram_re        = 1'b1;
                                n_count       = r_count - rdq_pkg::CNT_W'(1);
                                n_pend        = 1'b1;
                                n_pend_last   = 1'b1;
                                n_pend_status = rdq_pkg::STAT_POPPED;
                                n_left        = '0;
                                n_state       = rdq_pkg::ST_BUSY;
                                if (i_s_tuser == rdq_pkg::CMD_POP_FRONT) begin
                                    ram_raddr = r_head;
                                    n_head    = rdq_pkg::ring_next(r_head);
                                end else begin
                                    ram_raddr = rdq_pkg::ring_prev(r_tail);
                                    n_tail    = rdq_pkg::ring_prev(r_tail);
                                end
                            end
                        end
                        rdq_pkg::CMD_LIST: begin
                            if (is_empty) begin
                                ld        = 1'b1;
                                ld_status = rdq_pkg::STAT_EMPTY;
                            end else begin
                                n_left  = r_count;
                                n_ptr   = r_head;
                                n_pend  = 1'b0;
                                n_state = rdq_pkg::ST_BUSY;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            rdq_pkg::ST_BUSY: begin
                move  = r_pend && out_free;
                issue = (r_left != '0) && (!r_pend || move);
                if (move) begin
                    ld          = 1'b1;
                    ld_from_ram = 1'b1;
                    ld_status   = r_pend_status;
                    ld_last     = r_pend_last;
                end
                if (issue) begin
                    ram_re        = 1'b1;
                    ram_raddr     = r_ptr;
                    n_ptr         = rdq_pkg::ring_next(r_ptr);
                    n_left        = r_left - rdq_pkg::CNT_W'(1);
                    n_pend_status = rdq_pkg::STAT_LISTED;
                    n_pend_last   = (r_left == rdq_pkg::CNT_W'(1));
                end
                n_pend = issue || (r_pend && !move);
                if (!n_pend && (n_left == '0)) begin
                    n_state = rdq_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rdq_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ld) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld) begin
            r_out_status <= ld_status;
            r_out_rec    <= ld_from_ram ? ram_rdata : '0;
            r_out_count  <= r_count;
            r_out_last   <= ld_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{rdq_pkg::M_PAD_W{1'b0}}, r_out_count, r_out_rec};
    assign o_m_tuser  = r_out_status;
    assign o_m_tlast  = r_out_last;

endmodule

// ----- rtl/rdq_checker.sv -----
// Port-level checker of the record deque, bound to the top level.
`include "assert_macros.svh"

module rdq_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_m_tvalid,
    input logic                           i_m_tready,
    input logic [rdq_pkg::M_TDATA_W-1:0]  o_m_tdata,
    input logic [rdq_pkg::STATUS_W-1:0]   o_m_tuser,
    input logic                           o_m_tlast
);

    logic                                          stall;
    logic [rdq_pkg::M_TDATA_W+rdq_pkg::STATUS_W:0] beat;
    rdq_pkg::t_cnt                                 count;
    logic                                          at_depth;
    logic                                          empty_beat;
    logic                                          full_beat;
    logic                                          one_beat;

    assign stall      = o_m_tvalid && !i_m_tready;
    assign beat       = {o_m_tlast, o_m_tuser, o_m_tdata};
    assign count      = o_m_tdata[rdq_pkg::CNT_LSB +: rdq_pkg::CNT_W];
    assign at_depth   = (count == rdq_pkg::CNT_W'(rdq_pkg::DEPTH));
    assign empty_beat = o_m_tvalid && (o_m_tuser == rdq_pkg::STAT_EMPTY);
    assign full_beat  = o_m_tvalid && (o_m_tuser == rdq_pkg::STAT_FULL);
    assign one_beat   = o_m_tvalid && (o_m_tuser != rdq_pkg::STAT_LISTED);

    `RDQ_ASSERT_NEXT(a_hold, i_clk, i_rst_n, stall, o_m_tvalid && $stable(beat), "beat changed")
    `RDQ_ASSERT_IMP(a_empty, i_clk, i_rst_n, empty_beat, count == '0, "empty with records")
    `RDQ_ASSERT_IMP(a_full, i_clk, i_rst_n, full_beat, at_depth, "full below depth")
    `RDQ_ASSERT_IMP(a_last, i_clk, i_rst_n, one_beat, o_m_tlast, "single beat without tlast")

endmodule

bind record_deque rdq_checker u_rdq_checker (.*);
